// File: rtl/pw1g_pkg.sv
// ----------------------------------------------------------------------------
// pw1g_pkg
// Types and constants shared by the 1 GiB page walker modules.
// ----------------------------------------------------------------------------
package pw1g_pkg;

	localparam int unsigned VA_W    = 48;
	localparam int unsigned PA_W    = 52;
	localparam int unsigned ENTRY_W = 64;
	localparam int unsigned BASE_W  = 40;

	// Input item kinds.
	localparam logic KIND_TRANSLATE = 1'b0;
	localparam logic KIND_ENTRY     = 1'b1;

	// Result item kinds.
	localparam logic RK_REQUEST = 1'b0;
	localparam logic RK_DONE    = 1'b1;

	// Entry bit positions.
	localparam int unsigned ENT_PRESENT = 0;
	localparam int unsigned ENT_PS      = 7;

	typedef enum logic [1:0] {
		PHASE_IDLE  = 2'd0,
		PHASE_PML4E = 2'd1,
		PHASE_PDPTE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_PML4E_ABSENT = 3'd1,
		ST_PDPTE_ABSENT = 3'd2,
		ST_NOT_1G       = 3'd3,
		ST_UNEXPECTED   = 3'd4
	} status_t;

	typedef struct packed {
		logic            result_kind;
		logic [PA_W-1:0] address;
		status_t         status;
		logic            identity_match;
	} walk_result_t;

	typedef struct packed {
		phase_t          phase;
		logic            save_vaddr;
		logic [VA_W-1:0] vaddr;
	} walk_next_t;

endpackage

// File: rtl/pw1g_step.sv
// ----------------------------------------------------------------------------
// pw1g_step
// Evaluates one item against the walk state: builds the result item and
// the next walk state.
// ----------------------------------------------------------------------------
module pw1g_step import pw1g_pkg::*; (
	input  logic               kind,
	input  logic [VA_W-1:0]    vaddr,
	input  logic [ENTRY_W-1:0] entry,
	input  phase_t             phase,
	input  logic [VA_W-1:0]    saved_vaddr,
	input  logic [BASE_W-1:0]  page_table_base,
	output walk_result_t       result,
	output walk_next_t         next
);

	logic            busy;
	logic [PA_W-1:0] pa;

	assign busy = (phase == PHASE_PML4E) || (phase == PHASE_PDPTE);
	assign pa   = {entry[51:30], saved_vaddr[29:0]};

	// Decode the item; anything out of order finishes as unexpected.
	always_comb begin
		result.result_kind    = RK_DONE;
		result.address        = '0;
		result.status         = ST_UNEXPECTED;
		result.identity_match = 1'b0;
		next.phase            = phase;
		next.save_vaddr       = 1'b0;
		next.vaddr            = vaddr;

		if (kind == KIND_TRANSLATE) begin
			if (!busy) begin
				result.result_kind = RK_REQUEST;
				result.address     = {page_table_base, vaddr[47:39], 3'b000};
				result.status      = ST_OK;
				next.phase         = PHASE_PML4E;
				next.save_vaddr    = 1'b1;
			end
		end else begin
			unique case (phase)
				PHASE_PML4E: begin
					if (!entry[ENT_PRESENT]) begin
						result.status = ST_PML4E_ABSENT;
						next.phase    = PHASE_IDLE;
					end else begin
						result.result_kind = RK_REQUEST;
						result.address     = {entry[51:12], saved_vaddr[38:30], 3'b000};
						result.status      = ST_OK;
						next.phase         = PHASE_PDPTE;
					end
				end
				PHASE_PDPTE: begin
					next.phase = PHASE_IDLE;
					if (!entry[ENT_PRESENT]) begin
						result.status = ST_PDPTE_ABSENT;
					end else if (!entry[ENT_PS]) begin
						result.status = ST_NOT_1G;
					end else begin
						result.address        = pa;
						result.status         = ST_OK;
						result.identity_match = (pa == {{(PA_W-VA_W){1'b0}}, saved_vaddr});
					end
				end
				default: begin
					next.phase = PHASE_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/page_walk_1g_translate.sv
// ----------------------------------------------------------------------------
// page_walk_1g_translate
// Two-level walker for 1 GiB pages that turns table reads into a
// request/response exchange on one item channel.
// ----------------------------------------------------------------------------
// Each input item produces exactly one result item via the input and result
// registers. The block takes one item every cycle while the output is not
// stalled: an input register feeds a single pass of slicing and present/page-
// size checks into a result register, and the walk phase and saved virtual
// address update as each item moves into the result register, so the next
// item already sees them. page_table_base is written through the config
// port, which is always ready, and is meant to change only while idle.
// ----------------------------------------------------------------------------
module page_walk_1g_translate import pw1g_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BASE_W-1:0]  cfg_data,
	// Input item channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [VA_W-1:0]    vaddr,
	input  logic [ENTRY_W-1:0] entry,
	// Result item channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [PA_W-1:0]    address,
	output logic [2:0]         status,
	output logic               identity_match
);

	logic               valid_s1;
	logic               kind_s1;
	logic [VA_W-1:0]    vaddr_s1;
	logic [ENTRY_W-1:0] entry_s1;

	logic               out_valid_q;
	walk_result_t       result_q;

	phase_t             phase_q;
	logic [VA_W-1:0]    saved_vaddr_q;
	logic [BASE_W-1:0]  base_q;

	logic               out_free;
	logic               advance;
	logic               in_take;
	walk_result_t       result;
	walk_next_t         next;

	// Handshake: the result register frees when empty or being taken.
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= kind;
			vaddr_s1 <= vaddr;
			entry_s1 <= entry;
		end
	end

	pw1g_step u_step (
		.kind            (kind_s1),
		.vaddr           (vaddr_s1),
		.entry           (entry_s1),
		.phase           (phase_q),
		.saved_vaddr     (saved_vaddr_q),
		.page_table_base (base_q),
		.result          (result),
		.next            (next)
	);

	// Walk state follows each item as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PHASE_IDLE;
			saved_vaddr_q <= '0;
		end else if (advance) begin
			phase_q <= next.phase;
			if (next.save_vaddr) begin
				saved_vaddr_q <= next.vaddr;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = result_q.result_kind;
	assign address        = result_q.address;
	assign status         = result_q.status;
	assign identity_match = result_q.identity_match;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the 1 GiB page walker item by item. A software copy of the walk
// (phase, held virtual address, table base) predicts the result of every
// accepted item. The checker compares each result field by field with the
// oldest prediction. Directed fault and extreme cases run first, then
// random walks under several table bases and idle settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pw1g_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [BASE_W-1:0]  cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [VA_W-1:0]    vaddr;
	logic [ENTRY_W-1:0] entry;
	logic               out_valid;
	logic               out_stall;
	logic               result_kind;
	logic [PA_W-1:0]    address;
	logic [2:0]         status;
	logic               identity_match;

	// Walk state as the testbench expects it to be.
	phase_t            walk_phase_copy;
	logic [VA_W-1:0]   held_vaddr;
	logic [BASE_W-1:0] table_base;

	walk_result_t pending_walk_results[$];
	int           mismatch_count;
	int           items_sent;
	int           send_gap_max;
	int           result_stall_max;

	page_walk_1g_translate DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.vaddr          (vaddr),
		.entry          (entry),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.address        (address),
		.status         (status),
		.identity_match (identity_match)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Advances the expected walk by one item and returns the result it causes.
	function automatic walk_result_t predict_walk_step(logic item_kind,
			logic [VA_W-1:0] va, logic [ENTRY_W-1:0] ent);
		walk_result_t r;
		logic [PA_W-1:0] pa;
		r = '{result_kind: RK_DONE, address: '0, status: ST_UNEXPECTED,
			identity_match: 1'b0};
		if (item_kind == KIND_TRANSLATE) begin
			// A translate only starts a walk when none is in progress.
			if (walk_phase_copy == PHASE_IDLE) begin
				held_vaddr = va;
				walk_phase_copy = PHASE_PML4E;
				r.result_kind = RK_REQUEST;
				r.address = {table_base, va[47:39], 3'b000};
				r.status = ST_OK;
			end
		end else if (walk_phase_copy == PHASE_PML4E) begin
			if (!ent[ENT_PRESENT]) begin
				walk_phase_copy = PHASE_IDLE;
				r.status = ST_PML4E_ABSENT;
			end else begin
				walk_phase_copy = PHASE_PDPTE;
				r.result_kind = RK_REQUEST;
				r.address = {ent[51:12], held_vaddr[38:30], 3'b000};
				r.status = ST_OK;
			end
		end else if (walk_phase_copy == PHASE_PDPTE) begin
			walk_phase_copy = PHASE_IDLE;
			if (!ent[ENT_PRESENT]) begin
				r.status = ST_PDPTE_ABSENT;
			end else if (!ent[ENT_PS]) begin
				r.status = ST_NOT_1G;
			end else begin
				pa = {ent[51:30], held_vaddr[29:0]};
				r.address = pa;
				r.status = ST_OK;
				r.identity_match = (pa == {4'b0000, held_vaddr});
			end
		end else begin
			walk_phase_copy = PHASE_IDLE;
		end
		return r;
	endfunction

	// Sends one item after a random gap and records its expected result.
	task automatic send_item(logic item_kind, logic [VA_W-1:0] va,
			logic [ENTRY_W-1:0] ent);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= item_kind;
		vaddr <= va;
		entry <= ent;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		pending_walk_results.push_back(predict_walk_step(item_kind, va, ent));
		items_sent++;
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_walk_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the table base register; only called while the block is idle.
	task automatic write_base(logic [BASE_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_base = value;
	endtask

	function automatic logic [VA_W-1:0] random_vaddr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [ENTRY_W-1:0] random_entry();
		return {32'($urandom), 32'($urandom)};
	endfunction

	// Unexpected items, absent entries and a table entry that is not a 1G page.
	task automatic test_fault_cases();
		write_base({BASE_W{1'b1}});
		send_item(KIND_ENTRY, {VA_W{1'b1}}, {ENTRY_W{1'b1}});
		send_item(KIND_TRANSLATE, {VA_W{1'b1}}, '0);
		send_item(KIND_TRANSLATE, '0, {ENTRY_W{1'b1}});
		send_item(KIND_ENTRY, '0, {{(ENTRY_W-1){1'b1}}, 1'b0});
		send_item(KIND_TRANSLATE, '0, '0);
		send_item(KIND_ENTRY, '0, {ENTRY_W{1'b1}});
		send_item(KIND_ENTRY, '0, {{(ENTRY_W-1){1'b1}}, 1'b0});
		send_item(KIND_TRANSLATE, random_vaddr(), random_entry());
		send_item(KIND_ENTRY, random_vaddr(), 64'h1);
		send_item(KIND_TRANSLATE, random_vaddr(), random_entry());
		send_item(KIND_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FF7F);
		send_item(KIND_ENTRY, '0, '0);
		wait_idle();
	endtask

	// Zero and all-ones fields, and walks that map an address onto itself.
	task automatic test_extreme_fields();
		write_base('0);
		send_item(KIND_TRANSLATE, '0, '0);
		send_item(KIND_ENTRY, '0, 64'h1);
		send_item(KIND_ENTRY, '0, 64'h81);
		send_item(KIND_TRANSLATE, {VA_W{1'b1}}, '0);
		send_item(KIND_ENTRY, '0, {ENTRY_W{1'b1}});
		send_item(KIND_ENTRY, '0, {ENTRY_W{1'b1}});
		send_item(KIND_TRANSLATE, {VA_W{1'b1}}, '0);
		send_item(KIND_ENTRY, '0, 64'h1);
		send_item(KIND_ENTRY, '0, {12'hFFF, 4'h0, 18'h3FFFF, 30'h3FFF_FFFF});
		wait_idle();
	endtask

	// One walk with random content, now and then broken or surrounded by noise.
	task automatic random_walk();
		logic [VA_W-1:0]    va;
		logic [ENTRY_W-1:0] ent;
		int                 pick;
		if ($urandom_range(0, 19) == 0)
			send_item(KIND_ENTRY, random_vaddr(), random_entry());
		va = random_vaddr();
		send_item(KIND_TRANSLATE, va, random_entry());
		if ($urandom_range(0, 19) == 0)
			send_item(KIND_TRANSLATE, random_vaddr(), random_entry());
		// Top-level entry, absent about one time in ten.
		ent = random_entry();
		pick = $urandom_range(0, 9);
		ent[ENT_PRESENT] = (pick != 0);
		send_item(KIND_ENTRY, random_vaddr(), ent);
		if (pick == 0)
			return;
		if ($urandom_range(0, 19) == 0)
			send_item(KIND_TRANSLATE, random_vaddr(), random_entry());
		// Second-level entry: absent, small page, identity mapping or random frame.
		ent = random_entry();
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				ent[ENT_PRESENT] = 1'b0;
			end
			1: begin
				ent[ENT_PRESENT] = 1'b1;
				ent[ENT_PS] = 1'b0;
			end
			2, 3, 4: begin
				ent[51:30] = {4'b0000, va[47:30]};
				ent[ENT_PRESENT] = 1'b1;
				ent[ENT_PS] = 1'b1;
			end
			default: begin
				ent[ENT_PRESENT] = 1'b1;
				ent[ENT_PS] = 1'b1;
			end
		endcase
		send_item(KIND_ENTRY, random_vaddr(), ent);
	endtask

	// Random walks in phases with different bases and idle patterns.
	task automatic test_random_walks();
		int phase_end;
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: write_base('0);
				1: write_base({BASE_W{1'b1}});
				default: write_base({8'($urandom), 32'($urandom)});
			endcase
			case (p)
				2: begin
					send_gap_max = 0;
					result_stall_max = 0;
				end
				3: begin
					send_gap_max = 0;
					result_stall_max = 18;
				end
				4: begin
					send_gap_max = 18;
					result_stall_max = 0;
				end
				default: begin
					send_gap_max = 18;
					result_stall_max = 18;
				end
			endcase
			phase_end = items_sent + 94;
			while (items_sent < phase_end)
				random_walk();
		end
		wait_idle();
	endtask

	// Result side: a random stall before each result is taken.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, result_stall_max);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare every accepted result with the oldest expected one.
	initial begin
		walk_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_walk_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result with none expected: kind %0d addr %h",
							result_kind, address,
							" status %0d id %0d", status, identity_match);
				end else begin
					want = pending_walk_results.pop_front();
					if (result_kind !== want.result_kind || address !== want.address ||
							status !== want.status ||
							identity_match !== want.identity_match) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected kind %0d addr %h status %0d id %0d,",
								want.result_kind, want.address, want.status,
								want.identity_match,
								" got kind %0d addr %h status %0d id %0d",
								result_kind, address, status, identity_match);
					end
				end
			end
		end
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Reset, the tests in turn, and the final verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_TRANSLATE;
		vaddr <= '0;
		entry <= '0;
		out_stall <= 1'b0;
		walk_phase_copy = PHASE_IDLE;
		held_vaddr = '0;
		table_base = '0;
		mismatch_count = 0;
		items_sent = 0;
		send_gap_max = 18;
		result_stall_max = 18;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fault_cases();
		test_extreme_fields();
		test_random_walks();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && pending_walk_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// File: page_walk_1g_translate.f
rtl/pw1g_pkg.sv
rtl/pw1g_step.sv
rtl/page_walk_1g_translate.sv
test/testbench.sv
